@@ hw/rtl/urbc_pkg.sv @@
// Package for the UART ring-buffer controller: operation codes, ring command
// and status structs, and fixed field widths. No dependencies.
`default_nettype none

package urbc_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned ErrW   = 3;

  typedef enum logic [2:0] {
    OP_PUT      = 3'd0,
    OP_GET      = 3'd1,
    OP_FLUSH    = 3'd2,
    OP_RX_BYTE  = 3'd3,
    OP_TX_READY = 3'd4
  } op_e;

  // Latched receive error codes (one-hot bits).
  localparam logic [ErrW-1:0] ErrNone     = 3'b000;
  localparam logic [ErrW-1:0] ErrRingFull = 3'b100;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CountW-1:0] count;
  } ring_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/urbc_ring.sv @@
// One ring buffer with head and tail pointers and pre-increment indexing.
// Depends on urbc_pkg for the command and status structs.
`default_nettype none

module urbc_ring #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire urbc_pkg::ring_cmd_t      cmd_i,
  input  wire logic [urbc_pkg::DataW-1:0] wdata_i,
  output      logic [urbc_pkg::DataW-1:0] rdata_o,
  output      urbc_pkg::ring_status_t   status_o
);
  import urbc_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = (PtrW + 1 > CountW) ? PtrW + 1 : CountW;

  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0]  head_nx, tail_nx;
  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [CntW-1:0]  count_full;

  // Pointers wrap at DEPTH, which need not be a power of two.
  assign head_nx = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
  assign tail_nx = (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + PtrW'(1);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.push) begin
      head_d = head_nx;
    end
    if (cmd_i.flush) begin
      head_d = tail_q;
    end
    if (cmd_i.pop) begin
      tail_d = tail_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[head_nx] <= wdata_i;
    end
  end

  // Read data is registered and holds until the next pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      rdata_q <= mem_q[tail_nx];
    end
  end

  assign count_full = (head_q >= tail_q)
                    ? CntW'(head_q) - CntW'(tail_q)
                    : CntW'(head_q) + CntW'(DEPTH) - CntW'(tail_q);

  assign rdata_o        = rdata_q;
  assign status_o.full  = (head_nx == tail_q);
  assign status_o.empty = (head_q == tail_q);
  assign status_o.count = count_full[CountW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/uart_ring_buffer_controller_top.sv @@
// UART ring-buffer controller: each result beat appears in the cycle after its
// input beat is accepted; one beat is accepted every cycle while the result side
// keeps up, since the result register frees itself in the cycle it is taken.
// Each beat touches at most one pointer and one ring entry, read through a registered
// ring port that doubles as the result data register. Reset (rst_ni low,
// asynchronous) empties both rings, clears the latched error and the enable.
`default_nettype none

module uart_ring_buffer_controller_top #(
  parameter int unsigned RX_DEPTH = 32,
  parameter int unsigned TX_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [7:0] data_byte, [8] frame_error, [9] data_overrun, [15:10] zero
  input  wire logic [15:0] s_axis_tdata_i,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser_i,
  // Result stream.
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] rx_valid, [8:1] rx_data, [9] err_frame, [10] err_overrun,
  // [11] err_ring_overflow, [12] tx_valid, [20:13] tx_data, [21] tx_irq_enable,
  // [26:22] rx_count, [27] put_accepted, [31:28] zero
  output      logic [31:0] m_axis_tdata_o
);
  import urbc_pkg::*;

  logic             accept;
  op_e              op;
  logic [DataW-1:0] in_byte;
  logic             in_fe, in_dor;

  ring_cmd_t        tx_cmd, rx_cmd;
  ring_status_t     tx_stat, rx_stat;
  logic [DataW-1:0] tx_rdata, rx_rdata;

  logic             out_valid_q, out_valid_d;
  logic             rx_valid_q, rx_valid_d;
  logic             tx_valid_q, tx_valid_d;
  logic             put_ok_q, put_ok_d;
  logic [ErrW-1:0]  last_err_q, last_err_d;
  logic             irq_q, irq_d;

  logic [DataW-1:0] rx_data_out, tx_data_out;

  // The result register is free when empty or when its beat is taken now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign op      = op_e'(s_axis_tuser_i);
  assign in_byte = s_axis_tdata_i[7:0];
  assign in_fe   = s_axis_tdata_i[8];
  assign in_dor  = s_axis_tdata_i[9];

  // Ring commands. A put into a full ring and a received byte into a full ring
  // are both dropped; a get or tx-ready on an empty ring does not pop.
  always_comb begin
    tx_cmd       = '0;
    rx_cmd       = '0;
    tx_cmd.push  = accept && (op == OP_PUT) && !tx_stat.full;
    tx_cmd.pop   = accept && (op == OP_TX_READY) && !tx_stat.empty;
    rx_cmd.push  = accept && (op == OP_RX_BYTE) && !rx_stat.full;
    rx_cmd.pop   = accept && (op == OP_GET) && !rx_stat.empty;
    rx_cmd.flush = accept && (op == OP_FLUSH);
  end

  // Next values of the status registers: the latched error and the tx interrupt enable.
  always_comb begin
    last_err_d = last_err_q;
    irq_d      = irq_q;
    if (accept && (op == OP_RX_BYTE)) begin
      if (rx_stat.full) begin
        last_err_d = ErrRingFull;
      end else begin
        last_err_d = ErrNone | {1'b0, in_dor, in_fe};
      end
    end
    if (tx_cmd.push) begin
      irq_d = 1'b1;
    end else if (accept && (op == OP_TX_READY) && tx_stat.empty) begin
      irq_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rx_valid_d  = rx_valid_q;
    tx_valid_d  = tx_valid_q;
    put_ok_d    = put_ok_q;
    if (accept) begin
      out_valid_d = 1'b1;
      rx_valid_d  = rx_cmd.pop;
      tx_valid_d  = tx_cmd.pop;
      put_ok_d    = tx_cmd.push;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rx_valid_q  <= 1'b0;
      tx_valid_q  <= 1'b0;
      put_ok_q    <= 1'b0;
      last_err_q  <= ErrNone;
      irq_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      rx_valid_q  <= rx_valid_d;
      tx_valid_q  <= tx_valid_d;
      put_ok_q    <= put_ok_d;
      last_err_q  <= last_err_d;
      irq_q       <= irq_d;
    end
  end

  urbc_ring #(
    .DEPTH(TX_DEPTH)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tx_cmd),
    .wdata_i (in_byte),
    .rdata_o (tx_rdata),
    .status_o(tx_stat)
  );

  urbc_ring #(
    .DEPTH(RX_DEPTH)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (rx_cmd),
    .wdata_i (in_byte),
    .rdata_o (rx_rdata),
    .status_o(rx_stat)
  );

  // A new beat is only accepted once the pending result is taken, so the
  // error, enable and pointer state always match the beat on the output.
  assign rx_data_out = rx_valid_q ? rx_rdata : '0;
  assign tx_data_out = tx_valid_q ? tx_rdata : '0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, put_ok_q, rx_stat.count, irq_q, tx_data_out,
                            tx_valid_q, last_err_q[2], last_err_q[1], last_err_q[0],
                            rx_data_out, rx_valid_q};

  // A beat carries at most one kind of data: a get result or a tx byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rx_valid_q && tx_valid_q))
    else $error("rx and tx data valid in the same result beat");

  // An accepted put always leaves the transmit interrupt enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && put_ok_q) |-> irq_q)
    else $error("put accepted but tx interrupt enable is low");

  // A flush leaves an empty receive ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cmd.flush |=> (rx_stat.empty && (rx_stat.count == '0)))
    else $error("receive ring not empty after flush");

  // A ring-full drop latches the overflow bit alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_RX_BYTE) && rx_stat.full) |=> (last_err_q == ErrRingFull))
    else $error("ring overflow not latched");

endmodule

`default_nettype wire
